FILE: rtl/core/tdcs_pkg.sv
// Package for the three-axis deadband, clamp and slew limiter.
// Holds widths, fixed-point constants, register codes and the shared struct types.
// Depends on nothing.
`default_nettype none

package tdcs_pkg;

   localparam int FRAC_BITS = 14;
   localparam int NUM_AXES  = 3;
   localparam int CMD_W     = 16;
   localparam int LIM_W     = 15;
   localparam int RATE_W    = 20;
   localparam int DT_W      = 10;
   localparam int PROD_W    = RATE_W + DT_W;
   localparam int STEP_W    = 20;
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;

   localparam logic [LIM_W-1:0]        ONE_MAG = LIM_W'(1 << FRAC_BITS);
   localparam logic signed [CMD_W-1:0] ONE_CMD = CMD_W'(1 << FRAC_BITS);
   localparam logic [31:0]             DT_CAP_MS = 32'd1000;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_RESET  = 1'b1;

   // floor(p / 1000) = floor(floor(p / 8) / 125), the second by reciprocal multiply
   localparam int PRE_SHIFT   = 3;
   localparam int RECIP_IN_W  = PROD_W - PRE_SHIFT;
   localparam int RECIP_W     = 28;
   localparam int RECIP_SHIFT = 34;
   localparam int RECIP_PROD_W = RECIP_IN_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_125 = 28'd137438954;

   typedef enum logic [2:0] {
      REG_DEADBAND,
      REG_SURGE_LIMIT,
      REG_SWAY_LIMIT,
      REG_YAW_LIMIT,
      REG_SURGE_RATE,
      REG_SWAY_RATE,
      REG_YAW_RATE
   } reg_index_type;

   typedef struct packed {
      logic                    operation;
      logic [31:0]             now_ms;
      logic signed [CMD_W-1:0] surge_target;
      logic signed [CMD_W-1:0] sway_target;
      logic signed [CMD_W-1:0] yaw_target;
   } req_type;

   typedef struct packed {
      logic signed [CMD_W-1:0] surge_out;
      logic signed [CMD_W-1:0] sway_out;
      logic signed [CMD_W-1:0] yaw_out;
   } rsp_type;

   typedef struct packed {
      logic [LIM_W-1:0]                 deadband;
      logic [NUM_AXES-1:0][LIM_W-1:0]   limit;
      logic [NUM_AXES-1:0][RATE_W-1:0]  rate;
   } cfg_type;

   typedef struct packed {
      logic load_s1;
      logic load_s2;
      logic load_s3;
      logic load_out;
      logic direct;
      logic clamp;
   } lane_ctrl_type;

endpackage

`default_nettype wire

FILE: rtl/core/tdcs_csr.sv
// Configuration register file behind the APB-style port.
// Saturates deadband and limits to one and flags a clamp after each valid write.
// Depends on tdcs_pkg.
`default_nettype none

module tdcs_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [tdcs_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [tdcs_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [tdcs_pkg::DATA_W-1:0]  csr_prdata,
   output tdcs_pkg::cfg_type            cfg,
   output logic                         clamp
);
   import tdcs_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic             clamp_ff, clamp_in;
   logic             wr;
   logic [2:0]       idx;
   logic [LIM_W-1:0] mag_wr;

   assign wr  = csr_psel && csr_penable && csr_pwrite;
   assign idx = csr_paddr[4:2];
   assign mag_wr = (csr_pwdata[LIM_W-1:0] > ONE_MAG) ? ONE_MAG : csr_pwdata[LIM_W-1:0];

   always_comb begin
      cfg_in   = cfg_ff;
      clamp_in = 1'b0;
      if (wr) begin
         clamp_in = 1'b1;
         unique case (idx)
            REG_DEADBAND:    cfg_in.deadband = mag_wr;
            REG_SURGE_LIMIT: cfg_in.limit[0] = mag_wr;
            REG_SWAY_LIMIT:  cfg_in.limit[1] = mag_wr;
            REG_YAW_LIMIT:   cfg_in.limit[2] = mag_wr;
            REG_SURGE_RATE:  cfg_in.rate[0]  = csr_pwdata[RATE_W-1:0];
            REG_SWAY_RATE:   cfg_in.rate[1]  = csr_pwdata[RATE_W-1:0];
            REG_YAW_RATE:    cfg_in.rate[2]  = csr_pwdata[RATE_W-1:0];
            default:         clamp_in = 1'b0;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_DEADBAND:    csr_prdata = DATA_W'(cfg_ff.deadband);
         REG_SURGE_LIMIT: csr_prdata = DATA_W'(cfg_ff.limit[0]);
         REG_SWAY_LIMIT:  csr_prdata = DATA_W'(cfg_ff.limit[1]);
         REG_YAW_LIMIT:   csr_prdata = DATA_W'(cfg_ff.limit[2]);
         REG_SURGE_RATE:  csr_prdata = DATA_W'(cfg_ff.rate[0]);
         REG_SWAY_RATE:   csr_prdata = DATA_W'(cfg_ff.rate[1]);
         REG_YAW_RATE:    csr_prdata = DATA_W'(cfg_ff.rate[2]);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadband <= '0;
         cfg_ff.limit    <= {NUM_AXES{ONE_MAG}};
         cfg_ff.rate     <= '0;
         clamp_ff        <= 1'b0;
      end else begin
         cfg_ff   <= cfg_in;
         clamp_ff <= clamp_in;
      end
   end

   assign cfg   = cfg_ff;
   assign clamp = clamp_ff;

endmodule

`default_nettype wire

FILE: rtl/core/tdcs_lane.sv
// One axis lane: deadband and limit, rate times dt, divide by 1000, slew.
// Holds the axis's stored command, which is also the lane's result.
// Depends on tdcs_pkg.
`default_nettype none

module tdcs_lane (
   input  logic                               clock,
   input  logic                               reset,
   input  tdcs_pkg::lane_ctrl_type            ctrl,
   input  logic [tdcs_pkg::LIM_W-1:0]         deadband,
   input  logic [tdcs_pkg::LIM_W-1:0]         limit,
   input  logic [tdcs_pkg::RATE_W-1:0]        rate,
   input  logic [tdcs_pkg::DT_W-1:0]          dt,
   input  logic signed [tdcs_pkg::CMD_W-1:0]  target,
   output logic signed [tdcs_pkg::CMD_W-1:0]  axis_out
);
   import tdcs_pkg::*;

   localparam int WIDE_W = STEP_W + 2;

   logic signed [CMD_W-1:0]  sat_cmd, mag, lim_s, lim_tgt;
   logic signed [CMD_W-1:0]  tgt_s1_ff, tgt_s2_ff, tgt_s3_ff;
   logic [PROD_W-1:0]        prod_s2_ff, prod_s2_in;
   logic [RECIP_PROD_W-1:0]  recip_full;
   logic [STEP_W-1:0]        step_s3_ff, step_s3_in;
   logic signed [CMD_W-1:0]  axis_now_ff, axis_now_in, slew_cmd;
   logic signed [WIDE_W-1:0] cur_x, tgt_x, delta, step_x;

   always_comb begin
      if (target > ONE_CMD) begin
         sat_cmd = ONE_CMD;
      end else if (target < -ONE_CMD) begin
         sat_cmd = -ONE_CMD;
      end else begin
         sat_cmd = target;
      end
      mag   = (sat_cmd < 0) ? -sat_cmd : sat_cmd;
      lim_s = $signed({1'b0, limit});
      if (mag[LIM_W-1:0] < deadband) begin
         lim_tgt = '0;
      end else if (sat_cmd > lim_s) begin
         lim_tgt = lim_s;
      end else if (sat_cmd < -lim_s) begin
         lim_tgt = -lim_s;
      end else begin
         lim_tgt = sat_cmd;
      end
   end

   assign prod_s2_in = PROD_W'(rate) * PROD_W'(dt);
   assign recip_full = RECIP_PROD_W'(prod_s2_ff[PROD_W-1:PRE_SHIFT]) * RECIP_PROD_W'(RECIP_125);
   assign step_s3_in = recip_full[RECIP_SHIFT +: STEP_W];

   always_comb begin
      cur_x  = WIDE_W'(axis_now_ff);
      tgt_x  = WIDE_W'(tgt_s3_ff);
      step_x = $signed({2'b00, step_s3_ff});
      delta  = tgt_x - cur_x;
      if (ctrl.direct || (rate == '0)) begin
         slew_cmd = tgt_s3_ff;
      end else if (delta > step_x) begin
         slew_cmd = CMD_W'(cur_x + step_x);
      end else if (delta < -step_x) begin
         slew_cmd = CMD_W'(cur_x - step_x);
      end else begin
         slew_cmd = tgt_s3_ff;
      end
   end

   always_comb begin
      axis_now_in = axis_now_ff;
      if (ctrl.load_out) begin
         axis_now_in = slew_cmd;
      end else if (ctrl.clamp) begin
         if (axis_now_ff > lim_s) begin
            axis_now_in = lim_s;
         end else if (axis_now_ff < -lim_s) begin
            axis_now_in = -lim_s;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_s1) begin
         tgt_s1_ff <= lim_tgt;
      end
      if (ctrl.load_s2) begin
         tgt_s2_ff  <= tgt_s1_ff;
         prod_s2_ff <= prod_s2_in;
      end
      if (ctrl.load_s3) begin
         tgt_s3_ff  <= tgt_s2_ff;
         step_s3_ff <= step_s3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_now_ff <= '0;
      end else begin
         axis_now_ff <= axis_now_in;
      end
   end

   assign axis_out = axis_now_ff;

endmodule

`default_nettype wire

FILE: rtl/core/three_axis_deadband_clamp_slew_limiter.sv
// Top level of the three-axis deadband, clamp and slew limiter.
// Shares time-step and stage control across three tdcs_lane copies; config in tdcs_csr.
// Depends on tdcs_pkg, tdcs_csr, tdcs_lane.
//
//   port group  | dir | handshake               | carries
//   req_*       | in  | req_valid / req_stall   | req_type: operation, time, three targets
//   rsp_*       | out | rsp_valid / rsp_stall   | rsp_type: three stored commands
//   csr_*       | in  | csr_psel / csr_penable  | seven configuration registers
//
// One request per cycle while no stall holds the pipeline; each result passes through
// four register stages: limit, rate times dt, reciprocal divide by 1000, slew.
// Reset is synchronous: stored commands and time clear, limits load one, rates zero.
// A stalled result freezes only the stages behind it that are full; bubbles still fill.
`default_nettype none

module three_axis_deadband_clamp_slew_limiter (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  tdcs_pkg::req_type            req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output tdcs_pkg::rsp_type            rsp_payload,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [tdcs_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [tdcs_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [tdcs_pkg::DATA_W-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import tdcs_pkg::*;

   cfg_type                     cfg;
   logic                        clamp;
   lane_ctrl_type               ctrl;
   logic [NUM_AXES-1:0][CMD_W-1:0] targets, lane_out;

   logic        s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   logic        s1_v_in, s2_v_in, s3_v_in, out_v_in;
   logic        direct_s1_ff, direct_s2_ff, direct_s3_ff;
   logic        primed_ff, primed_in;
   logic [31:0] last_time_ff, last_time_in, diff;
   logic [DT_W-1:0] dt_s1_ff, dt_in;
   logic        out_ready, s3_ready, s2_ready, s1_ready;

   tdcs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg),
      .clamp       (clamp)
   );

   assign csr_pready = 1'b1;

   assign out_ready = !out_v_ff || !rsp_stall;
   assign s3_ready  = !s3_v_ff || out_ready;
   assign s2_ready  = !s2_v_ff || s3_ready;
   assign s1_ready  = !s1_v_ff || s2_ready;

   always_comb begin
      ctrl.load_s1  = req_valid && s1_ready;
      ctrl.load_s2  = s1_v_ff && s2_ready;
      ctrl.load_s3  = s2_v_ff && s3_ready;
      ctrl.load_out = s3_v_ff && out_ready;
      ctrl.direct   = direct_s3_ff;
      ctrl.clamp    = clamp;
   end

   assign req_stall = !s1_ready;

   assign diff  = req_payload.now_ms - last_time_ff;
   assign dt_in = (diff > DT_CAP_MS) ? DT_CAP_MS[DT_W-1:0] : diff[DT_W-1:0];

   always_comb begin
      s1_v_in      = ctrl.load_s1  || (s1_v_ff && !ctrl.load_s2);
      s2_v_in      = ctrl.load_s2  || (s2_v_ff && !ctrl.load_s3);
      s3_v_in      = ctrl.load_s3  || (s3_v_ff && !ctrl.load_out);
      out_v_in     = ctrl.load_out || (out_v_ff && rsp_stall);
      primed_in    = primed_ff || ctrl.load_s1;
      last_time_in = ctrl.load_s1 ? req_payload.now_ms : last_time_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         out_v_ff     <= 1'b0;
         primed_ff    <= 1'b0;
         last_time_ff <= '0;
      end else begin
         s1_v_ff      <= s1_v_in;
         s2_v_ff      <= s2_v_in;
         s3_v_ff      <= s3_v_in;
         out_v_ff     <= out_v_in;
         primed_ff    <= primed_in;
         last_time_ff <= last_time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_s1) begin
         dt_s1_ff     <= dt_in;
         direct_s1_ff <= (req_payload.operation == OP_RESET) || !primed_ff;
      end
      if (ctrl.load_s2) begin
         direct_s2_ff <= direct_s1_ff;
      end
      if (ctrl.load_s3) begin
         direct_s3_ff <= direct_s2_ff;
      end
   end

   assign targets[0] = req_payload.surge_target;
   assign targets[1] = req_payload.sway_target;
   assign targets[2] = req_payload.yaw_target;

   for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
      tdcs_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .deadband (cfg.deadband),
         .limit    (cfg.limit[g]),
         .rate     (cfg.rate[g]),
         .dt       (dt_s1_ff),
         .target   ($signed(targets[g])),
         .axis_out (lane_out[g])
      );
   end

   always_comb begin
      rsp_payload.surge_out = $signed(lane_out[0]);
      rsp_payload.sway_out  = $signed(lane_out[1]);
      rsp_payload.yaw_out   = $signed(lane_out[2]);
   end

   assign rsp_valid = out_v_ff;

`ifndef SYNTHESIS
   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.surge_out <= ONE_CMD) && (rsp_payload.surge_out >= -ONE_CMD)
                 && (rsp_payload.sway_out <= ONE_CMD) && (rsp_payload.sway_out >= -ONE_CMD)
                 && (rsp_payload.yaw_out <= ONE_CMD) && (rsp_payload.yaw_out >= -ONE_CMD))
      else $error("stored command outside plus or minus one");

   a_primed_holds: assert property (@(posedge clock) disable iff (reset)
      primed_ff |=> primed_ff)
      else $error("primed flag dropped without reset");

   a_state_stable: assert property (@(posedge clock) disable iff (reset)
      (!ctrl.load_out && !ctrl.clamp) |=> $stable(lane_out))
      else $error("stored command changed without an update or clamp");

   a_first_direct: assert property (@(posedge clock) disable iff (reset)
      (ctrl.load_s1 && !primed_ff) |=> direct_s1_ff)
      else $error("first request after reset not marked direct");
`endif

endmodule

`default_nettype wire
